/* rtl/core/dtp_pkg.sv */
// Shared constants for the binary64 to posit converter.
package dtp_pkg;

    localparam int PositBitsDef = 32;
    localparam int ExpBitsDef   = 2;

    localparam int FloatW  = 64;
    localparam int FracW   = 52;
    localparam int BexpW   = 11;
    localparam int OutW    = 32;
    localparam int ScaleW  = 13;

    localparam logic [BexpW-1:0] BexpZero = '0;
    localparam logic [BexpW-1:0] BexpMax  = '1;
    localparam int               ExpBias  = 1023;

endpackage

/* rtl/core/dtp_convert.sv */
// Combinational binary64 to posit conversion with round to nearest even.
module dtp_convert import dtp_pkg::*; #(
    parameter int POSIT_BITS    = PositBitsDef,
    parameter int EXPONENT_BITS = ExpBitsDef
) (
    input  logic [FloatW-1:0]     i_float_bits,
    output logic [POSIT_BITS-1:0] o_posit_bits
);

    localparam int TailW = EXPONENT_BITS + FracW;
    localparam int VecW  = TailW + POSIT_BITS;
    localparam int ShW   = $clog2(POSIT_BITS);
    localparam logic signed [ScaleW-1:0] MaxScale =
        ScaleW'((POSIT_BITS - 2) * (2 ** EXPONENT_BITS));
    localparam logic signed [ScaleW-1:0] MinScale = -MaxScale;
    localparam logic [POSIT_BITS-1:0] Nar    = POSIT_BITS'(1) << (POSIT_BITS - 1);
    localparam logic [POSIT_BITS-1:0] MaxPos = Nar - POSIT_BITS'(1);
    localparam logic [POSIT_BITS-1:0] MinPos = POSIT_BITS'(1);

    logic                     sign;
    logic [BexpW-1:0]         bexp;
    logic [FracW-1:0]         frac;
    logic [FloatW-1:0]        norm;
    logic [5:0]               lzc;
    logic [FracW-1:0]         frac_n;
    logic signed [ScaleW-1:0] scale;
    logic signed [ScaleW-1:0] k;
    logic                     kneg;
    logic [ShW-1:0]           sh;
    logic [TailW-1:0]         tail;
    logic [VecW-1:0]          seed;
    logic signed [VecW-1:0]   str;
    logic [POSIT_BITS-2:0]    body;
    logic                     guard;
    logic                     sticky;
    logic [POSIT_BITS-1:0]    mag;
    logic [POSIT_BITS-1:0]    signed_mag;

    assign sign = i_float_bits[FloatW-1];
    assign bexp = i_float_bits[FracW +: BexpW];
    assign frac = i_float_bits[FracW-1:0];

    // subnormal normalisation: six-step binary leading-zero search
    always_comb begin
        norm = {frac, (FloatW - FracW)'(0)};
        lzc  = '0;
        for (int s = 5; s >= 0; s--) begin
            if ((norm >> (FloatW - (1 << s))) == '0) begin
                norm   = norm << (1 << s);
                lzc[s] = 1'b1;
            end
        end
        frac_n = norm[FloatW-2 -: FracW];
    end

    always_comb begin
        if (bexp == BexpZero) begin
            scale = ScaleW'(-ExpBias) - ScaleW'(lzc);
        end else begin
            scale = ScaleW'(bexp) - ScaleW'(ExpBias);
        end
    end

    // floor division and non-negative remainder by 2^es
    assign k    = scale >>> EXPONENT_BITS;
    assign kneg = k[ScaleW-1];
    assign sh   = kneg ? ~k[ShW-1:0] : k[ShW-1:0];
    assign tail = (TailW'(unsigned'(scale)) << FracW)
                | TailW'((bexp == BexpZero) ? frac_n : frac);

    // regime run comes from sign-extending a two-bit seed
    assign seed = {~kneg, kneg, tail, (POSIT_BITS - 2)'(0)};
    assign str  = $signed(seed) >>> sh;

    assign body   = str[VecW-1 -: POSIT_BITS-1];
    assign guard  = str[TailW];
    assign sticky = |str[TailW-1:0];

    always_comb begin
        if (scale > MaxScale) begin
            mag = MaxPos;
        end else if (scale < MinScale) begin
            mag = MinPos;
        end else begin
            mag = {1'b0, body} + POSIT_BITS'(guard & (sticky | body[0]));
        end
        signed_mag = sign ? (~mag + POSIT_BITS'(1)) : mag;
    end

    always_comb begin
        if (bexp == BexpZero && frac == '0) begin
            o_posit_bits = '0;
        end else if (bexp == BexpMax) begin
            o_posit_bits = Nar;
        end else begin
            o_posit_bits = signed_mag;
        end
    end

endmodule

/* rtl/core/double_to_posit_convert_top.sv */
// Binary64 to posit converter: two-register pipeline around the conversion logic.
// Path: a request is captured in the input register, then its result in the result register.
// Throughput: one request per cycle while not stalled; the conversion is one pass
// of logic between the input register and the result register.
// Reset: synchronous, active low; clears both valid flags, data registers unreset.
// Stalls: i_ready low holds a full result stage; o_ready drops only when both
// stages are full and i_ready is low.
module double_to_posit_convert_top import dtp_pkg::*; #(
    parameter int POSIT_BITS    = PositBitsDef,
    parameter int EXPONENT_BITS = ExpBitsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [FloatW-1:0] i_float_bits,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OutW-1:0]   o_posit_bits
);

    logic                       r_in_valid;
    logic                       n_in_valid;
    logic [FloatW-1:0]          r_float;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [OutW-1:0]            r_posit;
    logic [POSIT_BITS-1:0]      conv;
    logic [POSIT_BITS+OutW-1:0] conv_ext;
    logic                       adv_out;
    logic                       adv_in;

    assign adv_out = !r_out_valid || i_ready;
    assign adv_in  = !r_in_valid || adv_out;
    assign o_ready = adv_in;

    dtp_convert #(
        .POSIT_BITS    (POSIT_BITS),
        .EXPONENT_BITS (EXPONENT_BITS)
    ) u_convert (
        .i_float_bits (r_float),
        .o_posit_bits (conv)
    );

    // wide posits keep their low word only
    assign conv_ext = {OutW'(0), conv};

    always_comb begin
        n_in_valid  = adv_in ? i_valid : r_in_valid;
        n_out_valid = adv_out ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_valid) begin
            r_float <= i_float_bits;
        end
        if (adv_out && r_in_valid) begin
            r_posit <= conv_ext[OutW-1:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_posit_bits = r_posit;

endmodule

/* rtl/core/dtp_check.sv */
// Port-level checker for the converter, bound to the top level.
module dtp_check import dtp_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input logic            o_valid,
    input logic            i_ready,
    input logic [OutW-1:0] o_posit_bits
);

    // nothing is shown straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_posit_bits))
        else $error("stalled result changed");

    // back-pressure only when both stages are full and the sink stalls
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without output back-pressure");

    // an accepted request passes from the input register to the output when the sink is ready
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready |=> o_valid)
        else $error("request lost in pipeline");

endmodule

bind double_to_posit_convert_top dtp_check u_dtp_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_posit_bits (o_posit_bits)
);
